FILE: rtl/erq_pkg.sv
// Shared types and codes for the elevator request queue.
// Used by the cell, the controller, the top level and the checker; depends on nothing.
package erq_pkg;

  localparam int COUNT_W = 5;

  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_CHECK    = 3'd1;
  localparam logic [2:0] MODE_NEXT     = 3'd2;
  localparam logic [2:0] MODE_COMPLETE = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;

  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_CMD  = 2'd2;

  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_STOP = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  localparam logic [1:0] STATUS_EMPTY   = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH = 2'd1;
  localparam logic [1:0] STATUS_MATCH   = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SCAN,
    CELL_MARK,
    CELL_COMPACT,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cell_op_t   op;
    logic       start;
    logic [1:0] floor;
    logic [1:0] btype;
    logic [1:0] want;
    logic       any;
  } cell_cmd_t;

  typedef struct packed {
    logic       live;
    logic       keep;
    logic [1:0] floor;
    logic [1:0] btype;
  } cell_link_t;

  typedef struct packed {
    logic hit;
    logic tok_end;
    logic hole;
    logic die;
  } cell_flags_t;

  typedef struct packed {
    logic       any_hit;
    logic       any_end;
    logic       any_hole;
    logic       any_die;
    logic [1:0] head_floor;
  } queue_flags_t;

  localparam cell_link_t LINK_OPEN = '{live: 1'b1, keep: 1'b1, floor: 2'd0, btype: 2'd0};
  localparam cell_link_t LINK_NONE = '{live: 1'b0, keep: 1'b0, floor: 2'd0, btype: 2'd0};

endpackage

FILE: rtl/erq_cell.sv
// One queue slot: holds a request and trades it with its neighbors.
// Depends on erq_pkg for the command, link and flag types.
module erq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  erq_pkg::cell_cmd_t   cmd,
  input  logic                 tok_in,
  input  erq_pkg::cell_link_t  left,
  input  erq_pkg::cell_link_t  right,
  output erq_pkg::cell_link_t  link,
  output logic                 tok_pass,
  output erq_pkg::cell_flags_t flags
);
  import erq_pkg::*;

  logic       live;
  logic       keep;
  logic       tok;
  logic [1:0] floor;
  logic [1:0] btype;

  logic cand;
  logic hole;
  logic left_hole;
  logic right_good;
  logic push_here;

  always_comb begin
    cand = live && (floor == cmd.floor) &&
           ((btype == cmd.want) || cmd.any || (btype == BTN_CMD));
    hole       = live && !keep;
    left_hole  = left.live && !left.keep;
    right_good = right.live && right.keep;
    push_here  = !live && left.live;
    tok_pass   = tok && live && !cand;

    flags.hit     = tok && cand;
    flags.tok_end = tok && !live;
    flags.hole    = hole;
    flags.die     = hole && !right.live;

    link.live  = live;
    link.keep  = keep;
    link.floor = floor;
    link.btype = btype;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
      keep <= 1'b0;
      tok  <= 1'b0;
    end else begin
      tok <= tok_in;
      case (cmd.op)
        CELL_PUSH: begin
          if (push_here) begin
            live <= 1'b1;
            keep <= 1'b1;
          end
        end
        CELL_SCAN: begin
          if (tok && cand) begin
            keep <= 1'b0;
          end
        end
        CELL_MARK: begin
          if (live && (floor == cmd.floor)) begin
            keep <= 1'b0;
          end
        end
        CELL_COMPACT: begin
          if (hole && right_good) begin
            keep <= 1'b1;
          end else if (live && keep && left_hole) begin
            keep <= 1'b0;
          end else if (hole && !right.live) begin
            live <= 1'b0;
          end
        end
        CELL_CLEAR: begin
          live <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == CELL_PUSH) && push_here) begin
      floor <= cmd.floor;
      btype <= cmd.btype;
    end else if ((cmd.op == CELL_COMPACT) && hole && right_good) begin
      floor <= right.floor;
      btype <= right.btype;
    end
  end

endmodule

FILE: rtl/erq_ctrl.sv
// Sequencer for the request queue: decodes each beat, drives the cell row and
// holds the result register. Depends on erq_pkg.
module erq_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            mode,
  input  logic [1:0]            req_floor,
  input  logic [1:0]            req_type,
  input  logic [1:0]            current_floor,
  input  logic [1:0]            travel_dir,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            order_status,
  output logic [1:0]            next_dir,
  output logic                  queue_empty,
  output logic [4:0]            queue_count,
  output logic                  push_dropped,
  input  erq_pkg::queue_flags_t qflags,
  output erq_pkg::cell_cmd_t    cmd
);
  import erq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [1:0]       cf_q;
  logic [1:0]       want_q;
  logic             any_q;
  logic [1:0]       status_q;
  logic [1:0]       ndir_q;
  logic             dropped_q;

  logic       accept;
  logic       full;
  logic       out_free;
  logic       chk_scan;
  logic [1:0] chk_status;
  logic [1:0] want_in;
  logic       any_in;
  logic [1:0] dir_in;

  always_comb begin
    accept   = in_valid && in_ready;
    full     = (count == CNT_W'(QUEUE_DEPTH));
    out_free = !out_valid || out_ready;

    want_in = BTN_CMD;
    any_in  = 1'b0;
    case (travel_dir)
      DIR_DOWN: want_in = BTN_DOWN;
      DIR_UP:   want_in = BTN_UP;
      DIR_STOP: any_in  = 1'b1;
      default: begin
      end
    endcase

    chk_scan   = 1'b0;
    chk_status = STATUS_MATCH;
    if (count == '0) begin
      chk_status = STATUS_EMPTY;
    end else if (travel_dir == DIR_NONE) begin
      chk_status = STATUS_NOMATCH;
    end else if (qflags.head_floor != current_floor) begin
      chk_scan = 1'b1;
    end

    dir_in = DIR_STOP;
    if (count != '0) begin
      if (qflags.head_floor > current_floor) begin
        dir_in = DIR_UP;
      end else if (qflags.head_floor < current_floor) begin
        dir_in = DIR_DOWN;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_CHECK:    state_next = chk_scan ? ST_SCAN : ST_FINISH;
            MODE_COMPLETE: state_next = ST_COMPACT;
            default:       state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (qflags.any_hit) begin
          state_next = ST_COMPACT;
        end else if (qflags.any_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_COMPACT: begin
        if (!qflags.any_hole) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    cmd.op    = CELL_HOLD;
    cmd.start = 1'b0;
    cmd.floor = cf_q;
    cmd.btype = req_type;
    cmd.want  = want_q;
    cmd.any   = any_q;
    case (state)
      ST_IDLE: begin
        cmd.floor = (mode == MODE_PUSH) ? req_floor : current_floor;
        if (accept) begin
          case (mode)
            MODE_PUSH:     cmd.op = full ? CELL_HOLD : CELL_PUSH;
            MODE_CHECK:    cmd.start = chk_scan;
            MODE_COMPLETE: cmd.op = CELL_MARK;
            MODE_CLEAR:    cmd.op = CELL_CLEAR;
            default: begin
            end
          endcase
        end
      end
      ST_SCAN:    cmd.op = CELL_SCAN;
      ST_COMPACT: cmd.op = CELL_COMPACT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && accept) begin
        if ((mode == MODE_PUSH) && !full) begin
          count <= count + CNT_W'(1);
        end else if (mode == MODE_CLEAR) begin
          count <= '0;
        end
      end else if ((state == ST_COMPACT) && qflags.any_die) begin
        count <= count - CNT_W'(1);
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cf_q      <= current_floor;
          want_q    <= want_in;
          any_q     <= any_in;
          status_q  <= (mode == MODE_CHECK) ? chk_status : STATUS_EMPTY;
          ndir_q    <= (mode == MODE_NEXT) ? dir_in : DIR_STOP;
          dropped_q <= (mode == MODE_PUSH) && full;
        end
      end
      ST_SCAN: begin
        if (qflags.any_hit) begin
          status_q <= STATUS_MATCH;
        end else if (qflags.any_end) begin
          status_q <= STATUS_NOMATCH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          order_status <= status_q;
          next_dir     <= ndir_q;
          queue_empty  <= (count == '0);
          queue_count  <= COUNT_W'(count);
          push_dropped <= dropped_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/elevator_request_queue.sv
// Top level of the elevator request queue: the sequencer and a row of cells.
// Depends on erq_pkg, erq_ctrl and erq_cell.
//
//   channel  direction  handshake             beat carries
//   in       sink       in_valid / in_ready   mode, req_floor, req_type, current_floor, travel_dir
//   out      source     out_valid / out_ready order_status, next_dir, queue_empty, queue_count,
//                                             push_dropped
//
// Push, next, clear and unused modes go from accept straight to the finish state, which loads the result
// into the output register once it is free. A check decided at the head does the same; otherwise a token walks
// the cell row one slot per cycle, and a removal then lets holes travel to the tail one slot per cycle.
// A complete marks the entries for its floor as holes and then compacts in the same way.
// A new beat is taken while the previous result still waits in the output register.
// Reset is synchronous and empties the queue.
module elevator_request_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [1:0] req_floor,
  input  logic [1:0] req_type,
  input  logic [1:0] current_floor,
  input  logic [1:0] travel_dir,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] order_status,
  output logic [1:0] next_dir,
  output logic       queue_empty,
  output logic [4:0] queue_count,
  output logic       push_dropped
);
  import erq_pkg::*;

  cell_cmd_t    cmd;
  queue_flags_t qflags;
  cell_link_t   links      [QUEUE_DEPTH];
  cell_link_t   left_link  [QUEUE_DEPTH];
  cell_link_t   right_link [QUEUE_DEPTH];
  cell_flags_t  cflags     [QUEUE_DEPTH];
  logic         tok_in     [QUEUE_DEPTH];
  logic         tok_pass   [QUEUE_DEPTH];

  erq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .req_floor    (req_floor),
    .req_type     (req_type),
    .current_floor(current_floor),
    .travel_dir   (travel_dir),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .order_status (order_status),
    .next_dir     (next_dir),
    .queue_empty  (queue_empty),
    .queue_count  (queue_count),
    .push_dropped (push_dropped),
    .qflags       (qflags),
    .cmd          (cmd)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_link[i] = LINK_OPEN;
      assign tok_in[i]    = cmd.start;
    end else begin : g_body
      assign left_link[i] = links[i-1];
      assign tok_in[i]    = tok_pass[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_link[i] = LINK_NONE;
    end else begin : g_inner
      assign right_link[i] = links[i+1];
    end

    erq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok_in[i]),
      .left    (left_link[i]),
      .right   (right_link[i]),
      .link    (links[i]),
      .tok_pass(tok_pass[i]),
      .flags   (cflags[i])
    );
  end

  always_comb begin
    qflags.any_hit    = 1'b0;
    qflags.any_end    = tok_pass[QUEUE_DEPTH-1];
    qflags.any_hole   = 1'b0;
    qflags.any_die    = 1'b0;
    qflags.head_floor = links[0].floor;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      qflags.any_hit  = qflags.any_hit  | cflags[i].hit;
      qflags.any_end  = qflags.any_end  | cflags[i].tok_end;
      qflags.any_hole = qflags.any_hole | cflags[i].hole;
      qflags.any_die  = qflags.any_die  | cflags[i].die;
    end
  end

endmodule

FILE: rtl/erq_checker.sv
// Port-level checks for the elevator request queue, bound to the top level.
// Depends on erq_pkg and on the port list of elevator_request_queue.
module erq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] order_status,
  input logic [1:0] next_dir,
  input logic       queue_empty,
  input logic [4:0] queue_count,
  input logic       push_dropped
);
  import erq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(order_status) && $stable(queue_count))
    else $error("result beat changed while stalled");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the result was produced");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |-> (queue_count == 5'd0) && !push_dropped)
    else $error("empty queue reported with entries or a drop");

  a_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && push_dropped |->
      (queue_count == COUNT_W'(QUEUE_DEPTH)) && (order_status == STATUS_EMPTY) &&
      (next_dir == DIR_STOP))
    else $error("dropped push without a full queue");

  a_next_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && (next_dir != DIR_STOP) |-> !queue_empty && (order_status == STATUS_EMPTY))
    else $error("direction given for an empty queue");

endmodule

bind elevator_request_queue erq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_erq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .order_status(order_status),
  .next_dir    (next_dir),
  .queue_empty (queue_empty),
  .queue_count (queue_count),
  .push_dropped(push_dropped)
);

FILE: tb/erq_result_checker.sv
`timescale 1ns / 100ps
// Checker for the elevator request queue: keeps its own copy of the request list,
// predicts one result beat per accepted request beat and compares in arrival order.
// Depends on erq_pkg only; it watches the ports and drives nothing into the block.
module erq_result_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] mode,
  input  logic [1:0] req_floor,
  input  logic [1:0] req_type,
  input  logic [1:0] current_floor,
  input  logic [1:0] travel_dir,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] order_status,
  input  logic [1:0] next_dir,
  input  logic       queue_empty,
  input  logic [4:0] queue_count,
  input  logic       push_dropped,
  output int         fail_count,
  output int         outstanding
);
  import erq_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] ndir;
    logic       empty;
    logic [4:0] count;
    logic       dropped;
  } queue_result_t;

  logic [1:0]    held_floor [QUEUE_DEPTH];
  logic [1:0]    held_type  [QUEUE_DEPTH];
  int            held_count;
  queue_result_t pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    held_count  = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void remove_request(input int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_floor[i] = held_floor[i + 1];
      held_type[i]  = held_type[i + 1];
    end
    held_count--;
  endfunction

  function automatic logic [1:0] check_floor(input logic [1:0] floor, input logic [1:0] dir);
    logic [1:0] button;
    if (held_count == 0) return STATUS_EMPTY;
    case (dir)
      DIR_DOWN: button = BTN_DOWN;
      DIR_UP:   button = BTN_UP;
      DIR_STOP: button = BTN_CMD;
      default:  return STATUS_NOMATCH;
    endcase
    if (held_floor[0] == floor) return STATUS_MATCH;
    for (int i = 0; i < held_count; i++) begin
      if (held_floor[i] == floor &&
          (held_type[i] == button || button == BTN_CMD || held_type[i] == BTN_CMD)) begin
        remove_request(i);
        return STATUS_MATCH;
      end
    end
    return STATUS_NOMATCH;
  endfunction

  function automatic queue_result_t predict_request(input logic [2:0] op, input logic [1:0] rf,
                                                    input logic [1:0] rt, input logic [1:0] cf,
                                                    input logic [1:0] td);
    queue_result_t res;
    int i;
    res.status  = STATUS_EMPTY;
    res.ndir    = DIR_STOP;
    res.dropped = 1'b0;
    case (op)
      MODE_PUSH: begin
        if (held_count >= QUEUE_DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          held_floor[held_count] = rf;
          held_type[held_count]  = rt;
          held_count++;
        end
      end
      MODE_CHECK: begin
        res.status = check_floor(cf, td);
      end
      MODE_NEXT: begin
        if (held_count > 0) begin
          if (held_floor[0] > cf) res.ndir = DIR_UP;
          else if (held_floor[0] < cf) res.ndir = DIR_DOWN;
        end
      end
      MODE_COMPLETE: begin
        i = 0;
        while (i < held_count) begin
          if (held_floor[i] == cf) remove_request(i);
          else i++;
        end
      end
      MODE_CLEAR: begin
        held_count = 0;
      end
      default: ;
    endcase
    res.empty = (held_count == 0);
    res.count = held_count[4:0];
    return res;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      held_count = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", queue_count, -1);
        end else begin
          want = pending_results.pop_front();
          if (order_status !== want.status)
            report_mismatch("order_status", order_status, want.status);
          if (next_dir !== want.ndir)
            report_mismatch("next_dir", next_dir, want.ndir);
          if (queue_empty !== want.empty)
            report_mismatch("queue_empty", queue_empty, want.empty);
          if (queue_count !== want.count)
            report_mismatch("queue_count", queue_count, want.count);
          if (push_dropped !== want.dropped)
            report_mismatch("push_dropped", push_dropped, want.dropped);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_request(mode, req_floor, req_type, current_floor,
                                                  travel_dir));
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/tb_elevator_request_queue.sv
`timescale 1ns / 100ps
// Testbench top for the elevator request queue: clock, reset, request stimulus and
// result back-pressure, with the verdict. Depends on erq_pkg, the block and erq_result_checker.
module tb_elevator_request_queue;
  import erq_pkg::*;

  localparam int         QUEUE_DEPTH  = 16;
  localparam int         ITEM_TARGET  = 1850;
  localparam int         QUIET_ITEMS  = 200;
  localparam int         STALL_CYCLES = 80;
  localparam int         DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int         TIMEOUT_NS   = 4_800_000;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [1:0] BTN_SPARE     = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] mode = MODE_PUSH;
  logic [1:0] req_floor = 2'd0;
  logic [1:0] req_type = BTN_UP;
  logic [1:0] current_floor = 2'd0;
  logic [1:0] travel_dir = DIR_STOP;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] order_status;
  logic [1:0] next_dir;
  logic       queue_empty;
  logic [4:0] queue_count;
  logic       push_dropped;

  int fail_count;
  int outstanding;
  int requests_sent = 0;
  int stall_requests = 0;
  int stall_served = 0;
  bit quiet = 1'b0;

  always #4 clk = ~clk;

  elevator_request_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .req_floor(req_floor), .req_type(req_type),
    .current_floor(current_floor), .travel_dir(travel_dir),
    .out_valid(out_valid), .out_ready(out_ready),
    .order_status(order_status), .next_dir(next_dir), .queue_empty(queue_empty),
    .queue_count(queue_count), .push_dropped(push_dropped)
  );

  erq_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .req_floor(req_floor), .req_type(req_type),
    .current_floor(current_floor), .travel_dir(travel_dir),
    .out_valid(out_valid), .out_ready(out_ready),
    .order_status(order_status), .next_dir(next_dir), .queue_empty(queue_empty),
    .queue_count(queue_count), .push_dropped(push_dropped),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  task automatic send_request(input logic [2:0] op, input logic [1:0] rf, input logic [1:0] rt,
                              input logic [1:0] cf, input logic [1:0] td);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= op;
    req_floor     <= rf;
    req_type      <= rt;
    current_floor <= cf;
    travel_dir    <= td;
    do @(posedge clk); while (!in_ready);
    if (op <= MODE_CLEAR) requests_sent++;
  endtask

  function automatic logic [1:0] pick_button();
    if ($urandom_range(0, 9) == 0) return BTN_SPARE;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [1:0] pick_direction();
    if ($urandom_range(0, 9) == 0) return DIR_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic push_burst(input int n);
    repeat (n) send_request(MODE_PUSH, 2'($urandom), pick_button(), 2'($urandom), 2'($urandom));
  endtask

  task automatic serve_floor();
    logic [1:0] cf;
    cf = 2'($urandom);
    send_request(MODE_NEXT, 2'($urandom), 2'($urandom), cf, 2'($urandom));
    repeat ($urandom_range(1, 3))
      send_request(MODE_CHECK, 2'($urandom), 2'($urandom), cf, pick_direction());
    if ($urandom_range(0, 1) == 0)
      send_request(MODE_COMPLETE, 2'($urandom), 2'($urandom), cf, 2'($urandom));
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_served < stall_requests) begin
        stall_served++;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int pick;
    bit mid_stall;
    mid_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd0, DIR_STOP);
    send_request(MODE_NEXT, 2'd0, BTN_UP, 2'd3, DIR_STOP);
    send_request(MODE_COMPLETE, 2'd3, BTN_CMD, 2'd0, DIR_UP);
    send_request(MODE_CLEAR, 2'd1, BTN_DOWN, 2'd3, DIR_DOWN);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      send_request(3'(m), 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
    send_request(MODE_PUSH, 2'd3, BTN_SPARE, 2'd0, DIR_NONE);
    send_request(MODE_PUSH, 2'd0, BTN_UP, 2'd3, DIR_DOWN);
    send_request(MODE_PUSH, 2'd2, BTN_DOWN, 2'd1, DIR_UP);
    send_request(MODE_PUSH, 2'd1, BTN_CMD, 2'd2, DIR_STOP);
    send_request(MODE_NEXT, 2'd2, BTN_UP, 2'd0, DIR_STOP);
    send_request(MODE_NEXT, 2'd1, BTN_CMD, 2'd3, DIR_DOWN);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd1, DIR_NONE);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd3, DIR_DOWN);
    send_request(MODE_CHECK, 2'd3, BTN_SPARE, 2'd2, DIR_DOWN);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd1, DIR_UP);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd0, DIR_DOWN);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd0, DIR_STOP);
    send_request(MODE_PUSH, 2'd2, BTN_UP, 2'd0, DIR_STOP);
    send_request(MODE_COMPLETE, 2'd0, BTN_UP, 2'd3, DIR_STOP);
    send_request(MODE_NEXT, 2'd0, BTN_UP, 2'd3, DIR_STOP);
    send_request(MODE_CHECK, 2'd0, BTN_UP, 2'd0, DIR_UP);
    send_request(MODE_CLEAR, 2'd0, BTN_UP, 2'd0, DIR_STOP);

    stall_requests++;
    while (requests_sent < ITEM_TARGET) begin
      if (requests_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
      if (!mid_stall && requests_sent >= ITEM_TARGET / 2) begin
        mid_stall = 1'b1;
        stall_requests++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) push_burst($urandom_range(1, 6));
      else if (pick < 70) serve_floor();
      else if (pick < 75) push_burst(QUEUE_DEPTH + $urandom_range(1, 3));
      else if (pick < 80)
        send_request(MODE_CLEAR, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      else
        send_request(3'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
